// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the calibrator RTL.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock outside reset.
`define PLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define PLC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/plc_pkg.sv =====
// Package for the piecewise linear calibrator: sizes, pipeline depths, stage types.
// No dependencies.
package plc_pkg;

   localparam int Points          = 7;
   localparam int KnotRegs        = 7;
   localparam int IdxW            = $clog2(KnotRegs);
   localparam int SampleW         = 16;
   localparam int KnotW           = 32;
   localparam int MagW            = 16;
   localparam int ProdW           = 2 * MagW;
   localparam int ResW            = 32;
   localparam int SumW            = ProdW + 2;
   localparam int DivBitsPerStage = 2;
   localparam int DivStages       = ProdW / DivBitsPerStage;
   localparam int Latency         = 3 + DivStages + 1;

   typedef struct packed {
      logic               flat;
      logic               neg;
      logic [MagW-1:0]    y1;
   } side_type;

   typedef struct packed {
      logic [ProdW-1:0]   dividend;
      logic [MagW-1:0]    divisor;
      side_type           side;
   } div_in_type;

   typedef struct packed {
      logic [ProdW-1:0]   quotient;
      side_type           side;
   } div_out_type;

endpackage

// ===== rtl/plc_front.sv =====
// Front end: segment search, differences and magnitudes, product (three stages).
// Depends on plc_pkg.
module plc_front
   import plc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [SampleW-1:0] sample,
   input  logic [KnotW-1:0]   knots [KnotRegs],
   output logic               out_valid,
   output div_in_type         out_data
);

   function automatic logic [MagW-1:0] mag17(logic [MagW:0] v);
      logic [MagW:0] t;
      t = v[MagW] ? ((MagW+1)'(0) - v) : v;
      return t[MagW-1:0];
   endfunction

   // stage A: segment search
   logic [IdxW-1:0]    j_in;
   logic               stop;
   logic               a_vld_ff;
   logic [SampleW-1:0] a_x_ff;
   logic [KnotW-1:0]   a_lo_ff, a_hi_ff;

   always_comb begin
      j_in = '0;
      stop = 1'b0;
      for (int k = 0; k < Points - 1; k++) begin
         if (!stop && (sample > knots[k][15:0]) && (knots[k+1][15:0] != '0)) begin
            j_in = IdxW'(k + 1);
         end else begin
            stop = 1'b1;
         end
      end
      if (j_in == '0) begin
         j_in = IdxW'(1);
      end
   end

   // stage B: differences
   logic [MagW:0]     dy, dx, den;
   logic              b_vld_ff, b_neg_ff, b_flat_ff;
   logic [MagW-1:0]   b_mdy_ff, b_mdx_ff, b_mden_ff, b_y1_ff;

   always_comb begin
      dy  = {a_hi_ff[31], a_hi_ff[31:16]} - {a_lo_ff[31], a_lo_ff[31:16]};
      dx  = {1'b0, a_x_ff} - {1'b0, a_lo_ff[15:0]};
      den = {1'b0, a_hi_ff[15:0]} - {1'b0, a_lo_ff[15:0]};
   end

   // stage C: product
   logic       c_vld_ff;
   div_in_type c_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff    <= sample;
      a_lo_ff   <= knots[j_in - IdxW'(1)];
      a_hi_ff   <= knots[j_in];
      b_mdy_ff  <= mag17(dy);
      b_mdx_ff  <= mag17(dx);
      b_mden_ff <= mag17(den);
      b_neg_ff  <= dy[MagW] ^ dx[MagW] ^ den[MagW];
      b_flat_ff <= (den == '0);
      b_y1_ff   <= a_lo_ff[31:16];
      c_data_ff.dividend  <= ProdW'(b_mdy_ff) * ProdW'(b_mdx_ff);
      c_data_ff.divisor   <= b_mden_ff;
      c_data_ff.side.flat <= b_flat_ff;
      c_data_ff.side.neg  <= b_neg_ff;
      c_data_ff.side.y1   <= b_y1_ff;
   end

   assign out_valid = c_vld_ff;
   assign out_data  = c_data_ff;

endmodule

// ===== rtl/plc_div.sv =====
// Pipelined unsigned restoring divider, DivBitsPerStage quotient bits per stage.
// Depends on plc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plc_div
   import plc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  div_in_type  in_data,
   output logic        out_valid,
   output div_out_type out_data
);

   typedef struct packed {
      logic [MagW-1:0]  rem;
      logic [ProdW-1:0] work;
   } div_state_type;

   function automatic div_state_type div_step(div_state_type st, logic [MagW-1:0] dvs);
      div_state_type r;
      logic [MagW:0] trial;
      r = st;
      for (int b = 0; b < DivBitsPerStage; b++) begin
         trial = {r.rem, r.work[ProdW-1]};
         if (trial >= {1'b0, dvs}) begin
            trial  = trial - {1'b0, dvs};
            r.rem  = trial[MagW-1:0];
            r.work = {r.work[ProdW-2:0], 1'b1};
         end else begin
            r.rem  = trial[MagW-1:0];
            r.work = {r.work[ProdW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic          vld_ff  [DivStages];
   div_state_type st_ff   [DivStages];
   logic [MagW-1:0] dvs_ff [DivStages];
   side_type      side_ff [DivStages];
   div_state_type st_in   [DivStages];

   always_comb begin
      st_in[0] = div_step('{rem: '0, work: in_data.dividend}, in_data.divisor);
      for (int s = 1; s < DivStages; s++) begin
         st_in[s] = div_step(st_ff[s-1], dvs_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DivStages; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < DivStages; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff[0]   <= st_in[0];
      dvs_ff[0]  <= in_data.divisor;
      side_ff[0] <= in_data.side;
      for (int s = 1; s < DivStages; s++) begin
         st_ff[s]   <= st_in[s];
         dvs_ff[s]  <= dvs_ff[s-1];
         side_ff[s] <= side_ff[s-1];
      end
   end

   assign out_valid         = vld_ff[DivStages-1];
   assign out_data.quotient = st_ff[DivStages-1].work;
   assign out_data.side     = side_ff[DivStages-1];

   `PLC_ASSERT_IMP(a_rem_below_divisor,
      vld_ff[DivStages-1] && (dvs_ff[DivStages-1] != '0),
      st_ff[DivStages-1].rem < dvs_ff[DivStages-1], "divider remainder not below divisor")

endmodule

// ===== rtl/plc_out.sv =====
// Output stage: sign, offset by the segment start value, saturation, flat-segment zeroing, result register.
// Depends on plc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plc_out
   import plc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  div_out_type      in_data,
   output logic             rsp_valid,
   output logic [ResW-1:0]  rsp_converted,
   output logic             rsp_clipped,
   output logic             rsp_flat_segment
);

   logic [SumW-1:0] q_s, sum;
   logic [ResW-1:0] conv_in;
   logic            clip_in, ovf;

   always_comb begin
      q_s = in_data.side.neg ? (SumW'(0) - {2'b00, in_data.quotient})
                             : {2'b00, in_data.quotient};
      sum = q_s + {{(SumW-MagW){in_data.side.y1[MagW-1]}}, in_data.side.y1};
      ovf = !((sum[SumW-1:ResW-1] == '0) || (sum[SumW-1:ResW-1] == '1));
      if (in_data.side.flat) begin
         conv_in = '0;
         clip_in = 1'b0;
      end else if (ovf) begin
         conv_in = sum[SumW-1] ? {1'b1, {(ResW-1){1'b0}}} : {1'b0, {(ResW-1){1'b1}}};
         clip_in = 1'b1;
      end else begin
         conv_in = sum[ResW-1:0];
         clip_in = 1'b0;
      end
   end

   logic            vld_ff, clip_ff, flat_ff;
   logic [ResW-1:0] conv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      conv_ff <= conv_in;
      clip_ff <= clip_in;
      flat_ff <= in_data.side.flat;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_converted    = conv_ff;
   assign rsp_clipped      = clip_ff;
   assign rsp_flat_segment = flat_ff;

   `PLC_ASSERT(a_clip_flat_excl, !(vld_ff && clip_ff && flat_ff),
      "clipped and flat segment both set")
   `PLC_ASSERT_IMP(a_flat_zero, vld_ff && flat_ff, conv_ff == '0,
      "flat segment result not zero")

endmodule

// ===== rtl/piecewise_linear_calibrator.sv =====
// A result strobes on rsp_valid once its accepted item has passed the front end, divider and output registers.
// Throughput: one item per cycle while reset is low; the 16-stage divider pipeline sets the depth, not the rate.
// busy is high only during reset; csr writes are taken whenever reset is low.
// Synchronous active-high reset clears the knot table and all pipeline valid bits.
// Top level: knot registers, front end, divider and output stage. Depends on plc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module piecewise_linear_calibrator
   import plc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [SampleW-1:0] req_sample,
   output logic               rsp_valid,
   output logic [ResW-1:0]    rsp_converted,
   output logic               rsp_clipped,
   output logic               rsp_flat_segment,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IdxW-1:0]    csr_index,
   input  logic [KnotW-1:0]   csr_wdata
);

   logic [KnotW-1:0] knot_ff [KnotRegs];

   assign busy      = reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KnotRegs; i++) begin
            knot_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready && (csr_index < IdxW'(KnotRegs))) begin
         knot_ff[csr_index] <= csr_wdata;
      end
   end

   logic        front_vld, div_vld;
   div_in_type  front_data;
   div_out_type div_data;

   plc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .sample    (req_sample),
      .knots     (knot_ff),
      .out_valid (front_vld),
      .out_data  (front_data)
   );

   plc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_vld),
      .in_data   (front_data),
      .out_valid (div_vld),
      .out_data  (div_data)
   );

   plc_out u_out (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (div_vld),
      .in_data          (div_data),
      .rsp_valid        (rsp_valid),
      .rsp_converted    (rsp_converted),
      .rsp_clipped      (rsp_clipped),
      .rsp_flat_segment (rsp_flat_segment)
   );

   `PLC_ASSERT_IMP(a_rsp_has_item, rsp_valid, $past(start && !busy, Latency),
      "result without an item accepted Latency cycles earlier")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for piecewise_linear_calibrator: loads knot tables over the csr port,
// sends samples and compares every result with an in-bench interpolation predictor.
// Depends on plc_pkg and the calibrator RTL.
module tb_top;
   import plc_pkg::*;

   typedef logic [KnotW-1:0] knot_set_t [KnotRegs];

   typedef struct {
      logic [ResW-1:0] converted;
      logic            clipped;
      logic            flat_segment;
   } conversion_t;

   typedef enum int {
      SORTED, EARLY_END, DUP_BP, STEEP, FILL_WORDS, RAW
   } table_style_e;

   localparam longint ResMax = 64'sd2147483647;
   localparam longint ResMin = -64'sd2147483648;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [SampleW-1:0] req_sample = '0;
   logic               rsp_valid;
   logic [ResW-1:0]    rsp_converted;
   logic               rsp_clipped;
   logic               rsp_flat_segment;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [IdxW-1:0]    csr_index = '0;
   logic [KnotW-1:0]   csr_wdata = '0;

   knot_set_t   knot_table = '{default: '0};
   conversion_t pending_results [$];
   int          mismatch_count = 0;
   int          gap_pct = 37;

   piecewise_linear_calibrator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_converted(rsp_converted),
      .rsp_clipped(rsp_clipped), .rsp_flat_segment(rsp_flat_segment),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic conversion_t convert_sample(input logic [SampleW-1:0] x);
      int unsigned seg;
      longint      x1, x2, y1, y2, v;
      conversion_t r;
      seg = 0;
      while (x > knot_table[seg][15:0] && seg < Points - 1 && knot_table[seg+1][15:0] != 0)
         seg++;
      if (seg == 0)
         seg = 1;
      x1 = longint'(knot_table[seg-1][15:0]);
      x2 = longint'(knot_table[seg][15:0]);
      y1 = longint'($signed(knot_table[seg-1][31:16]));
      y2 = longint'($signed(knot_table[seg][31:16]));
      r.clipped = 1'b0;
      r.flat_segment = 1'b0;
      if (x2 != x1) begin
         v = (y2 - y1) * (longint'(x) - x1) / (x2 - x1) + y1;
         if (v > ResMax) begin
            v = ResMax;
            r.clipped = 1'b1;
         end else if (v < ResMin) begin
            v = ResMin;
            r.clipped = 1'b1;
         end
      end else begin
         v = 0;
         r.flat_segment = 1'b1;
      end
      r.converted = v[ResW-1:0];
      return r;
   endfunction

   function automatic logic [KnotW-1:0] knot_word(input int unsigned bp, input int val);
      return {val[15:0], bp[15:0]};
   endfunction

   always @(posedge clock) begin
      conversion_t want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none actual %0d", $time,
                     $signed(rsp_converted));
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_converted !== want.converted) begin
               $display("%0t converted: expected %0d actual %0d", $time,
                        $signed(want.converted), $signed(rsp_converted));
               mismatch_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $display("%0t clipped: expected %0b actual %0b", $time,
                        want.clipped, rsp_clipped);
               mismatch_count++;
            end
            if (rsp_flat_segment !== want.flat_segment) begin
               $display("%0t flat_segment: expected %0b actual %0b", $time,
                        want.flat_segment, rsp_flat_segment);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_sample(input logic [SampleW-1:0] x);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         req_sample <= SampleW'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_sample <= x;
      do @(posedge clock); while (busy);
      pending_results.push_back(convert_sample(x));
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_knot(input logic [IdxW-1:0] idx, input logic [KnotW-1:0] word);
      if ($urandom_range(99) < gap_pct) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      do @(posedge clock); while (!csr_ready);
      if (idx < KnotRegs)
         knot_table[idx] = word;
   endtask

   // unused index 7 is poked now and then; the write must be dropped
   task automatic load_table(input knot_set_t words);
      for (int i = 0; i < KnotRegs; i++)
         write_knot(IdxW'(i), words[i]);
      if ($urandom_range(2) == 0)
         write_knot(IdxW'(KnotRegs), $urandom);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic knot_set_t random_table(input table_style_e style);
      knot_set_t   words;
      logic [15:0] bps [$];
      int unsigned pick, base;
      for (int i = 0; i < KnotRegs; i++) begin
         bps.push_back(16'($urandom));
         words[i] = $urandom;
      end
      if (style != RAW)
         bps.sort();
      case (style)
         EARLY_END: begin
            bps[$urandom_range(2, KnotRegs - 1)] = '0;
         end
         DUP_BP: begin
            pick = $urandom_range(1, KnotRegs - 1);
            bps[pick] = bps[pick-1];
         end
         STEEP: begin
            base = $urandom_range(1, 60000);
            for (int i = 0; i < KnotRegs; i++) begin
               bps[i] = 16'(base + i * $urandom_range(1, 3));
               words[i][31:16] = (i % 2 == 0) ? 16'h8000 : 16'h7fff;
            end
         end
         FILL_WORDS: begin
            pick = $urandom_range(3);
            for (int i = 0; i < KnotRegs; i++)
               words[i] = (pick == 0) ? 32'hffff_ffff : (pick == 1) ? 32'h8000_ffff :
                          (pick == 2) ? 32'h7fff_0001 : 32'h0000_0000;
            return words;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < KnotRegs; i++)
         words[i][15:0] = bps[i];
      return words;
   endfunction

   function automatic logic [SampleW-1:0] random_sample();
      int unsigned k;
      k = $urandom_range(KnotRegs - 1);
      case ($urandom_range(9))
         0, 1, 2, 3: return SampleW'($urandom);
         4, 5, 6:    return knot_table[k][15:0] + SampleW'($urandom_range(4)) - 16'd2;
         7:          return '0;
         8:          return '1;
         default:    return SampleW'($urandom_range(15));
      endcase
   endfunction

   task automatic test_reset_table();
      send_sample(16'd0);
      send_sample(16'hffff);
      wait_drain();
   endtask

   task automatic test_segments();
      load_table('{knot_word(100, -500), knot_word(1000, 200), knot_word(5000, 3000),
                   knot_word(20000, -7000), knot_word(40000, 12000),
                   knot_word(60000, 32767), knot_word(65535, -32768)});
      send_sample(16'd0);
      send_sample(16'd100);
      send_sample(16'd550);
      send_sample(16'd1000);
      send_sample(16'd30000);
      send_sample(16'd61234);
      send_sample(16'hffff);
      wait_drain();
   endtask

   // zero breakpoint at knot 3 ends the table; high samples extrapolate segment 2
   task automatic test_table_end();
      load_table('{knot_word(0, -100), knot_word(4000, 900), knot_word(9000, -2500),
                   knot_word(0, 5555), knot_word(50000, 1), knot_word(60000, 2),
                   knot_word(65000, 3)});
      send_sample(16'd2000);
      send_sample(16'd9000);
      send_sample(16'd50000);
      wait_drain();
   endtask

   task automatic test_flat_segment();
      load_table('{knot_word(500, 100), knot_word(500, 200), knot_word(800, -300),
                   knot_word(800, 400), knot_word(0, 7), knot_word(0, 8), knot_word(0, 9)});
      send_sample(16'd10);
      send_sample(16'd700);
      send_sample(16'd900);
      wait_drain();
   endtask

   task automatic test_clipping();
      load_table('{knot_word(1, -32768), knot_word(2, 32767), '0, '0, '0, '0, '0});
      send_sample(16'hffff);
      send_sample(16'd0);
      send_sample(16'd2);
      wait_drain();
      load_table('{knot_word(1, 32767), knot_word(2, -32768), '0, '0, '0, '0, '0});
      send_sample(16'hffff);
      send_sample(16'd1);
      wait_drain();
   endtask

   task automatic test_unordered();
      load_table('{knot_word(50000, 1000), knot_word(10000, -1000), knot_word(30000, 20000),
                   knot_word(5, -32768), knot_word(65535, 32767), knot_word(0, 0),
                   knot_word(7, 7)});
      send_sample(16'd0);
      send_sample(16'd40000);
      send_sample(16'hffff);
      wait_drain();
   endtask

   task automatic test_random();
      table_style_e style;
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: style = SORTED;
            4:          style = EARLY_END;
            5:          style = DUP_BP;
            6:          style = STEEP;
            7:          style = FILL_WORDS;
            default:    style = RAW;
         endcase
         load_table(random_table(style));
         gap_pct = (phase == 5) ? 0 : 37;
         for (int n = 0; n < 75; n++)
            send_sample(random_sample());
         wait_drain();
      end
      gap_pct = 37;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_table();
      test_segments();
      test_table_end();
      test_flat_segment();
      test_clipping();
      test_unordered();
      test_random();
      wait_drain();
      repeat (Latency + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
